@@ src/apc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package apc_pkg;

  localparam int SAMPLE_BITS_DEF = 24;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_ADDR_W-1:0] REG_THRESHOLD = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_SLOPE     = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_ATTACK    = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_RELEASE   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_MAKEUP    = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_WET       = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_BYPASS    = 3'd6;

  localparam logic signed [10:0] THRESHOLD_RST = -11'sd200;
  localparam logic [15:0]        SLOPE_RST     = 16'd49152;
  localparam logic [15:0]        ATTACK_RST    = 16'd65399;
  localparam logic [15:0]        RELEASE_RST   = 16'd65522;
  localparam logic signed [8:0]  MAKEUP_RST    = 9'sd0;
  localparam logic [16:0]        WET_RST       = 17'd65536;

  localparam logic [16:0] UNITY_Q16   = 17'd65536;
  localparam logic [15:0] RECIP5      = 16'd52429;
  localparam logic [10:0] DB_PER_LOG2 = 11'd1541;
  localparam logic [15:0] LOG2_PER_DB = 16'd43541;
  localparam logic [13:0] GR_MAX      = 14'd16383;

  function automatic logic [30:0] exp_k(input logic [3:0] idx);
    logic [30:0] k;
    case (idx)
      4'd0:    k = 31'd1518500250;
      4'd1:    k = 31'd1276901417;
      4'd2:    k = 31'd1170923762;
      4'd3:    k = 31'd1121280436;
      4'd4:    k = 31'd1097253708;
      4'd5:    k = 31'd1085434106;
      4'd6:    k = 31'd1079572136;
      4'd7:    k = 31'd1076653033;
      4'd8:    k = 31'd1075196444;
      4'd9:    k = 31'd1074468889;
      default: k = 31'd1073741824;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

@@ src/audio_peak_compressor_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// An item goes from acceptance through envelope, log, dB and exponential steps to a
// loaded result; a zero envelope skips the log and level steps, bypass skips all.
// A single 34 x 34 multiplier serves every multiplying step: the envelope update, 16
// squaring passes for the log, dB conversions, 10 exponential passes, gain and mix.
// The input is stalled while an item is in work or while its result waits on a stall.
// Synchronous reset clears the envelope, sequencer and output valid and loads defaults.
module audio_peak_compressor_core #(
  parameter int SAMPLE_BITS = apc_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [apc_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [apc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_in,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0]      sample_out,
  output logic [13:0]                        gain_reduction
);
  import apc_pkg::*;

  localparam int SB   = SAMPLE_BITS;
  localparam int ACCW = SB + 18;
  localparam int MW   = 34;

  typedef enum logic [14:0] {
    S_IDLE  = 15'b000000000000001,
    S_ENV   = 15'b000000000000010,
    S_NORM  = 15'b000000000000100,
    S_SQR   = 15'b000000000001000,
    S_THR   = 15'b000000000010000,
    S_LVL   = 15'b000000000100000,
    S_RED   = 15'b000000001000000,
    S_MKP   = 15'b000000010000000,
    S_GAIN  = 15'b000000100000000,
    S_EXPO  = 15'b000001000000000,
    S_SCALE = 15'b000010000000000,
    S_SHIFT = 15'b000100000000000,
    S_BLW   = 15'b001000000000000,
    S_BLD   = 15'b010000000000000,
    S_OUT   = 15'b100000000000000
  } state_t;

  state_t state;

  logic signed [10:0] threshold_db;
  logic [15:0]        compress_slope;
  logic [15:0]        attack_coeff;
  logic [15:0]        release_coeff;
  logic signed [8:0]  makeup_db;
  logic [16:0]        wet_level;
  logic               bypass_on;

  logic signed [SB-1:0] x;
  logic [SB-1:0]        mag;
  logic                 byp;
  logic [31:0]          env;
  logic [31:0]          nrm;
  logic [4:0]           p;
  logic [2:0]           nstep;
  logic [31:0]          m;
  logic [15:0]          res;
  logic [3:0]           cnt;
  logic signed [15:0]   t;
  logic signed [19:0]   over;
  logic [13:0]          gr;
  logic signed [16:0]   g;
  logic signed [15:0]   e;
  logic [63:0]          amag_p;
  logic signed [SB-1:0] wet;
  logic signed [ACCW-1:0] acc;

  logic signed [MW-1:0]   mul_a;
  logic signed [MW-1:0]   mul_b;
  logic signed [2*MW-1:0] prod;

  logic [31:0] mag32;
  logic        mag_gt;
  logic [31:0] env_diff;
  logic [31:0] env_next;
  logic [4:0]  amt;
  logic        top_zero;
  logic [31:0] nrm_next;
  logic [32:0] sq;
  logic [20:0] top_l;
  logic [20:0] log_l;
  logic [20:0] q;
  logic [10:0] thr_abs;
  logic [8:0]  mk_abs;
  logic [16:0] scaled_db;
  logic signed [16:0] mk_t;
  logic [19:0] gr_raw;
  logic [3:0]  fidx;
  logic signed [5:0] ip;
  logic [5:0]  sh;
  logic [63:0] amag;
  logic signed [SB+1:0] wet_full;
  logic signed [SB+1:0] y_full;
  logic [16:0] w;
  logic signed [SB-1:0] sat_hi;
  logic signed [SB-1:0] sat_lo;
  logic        out_load;

  assign sat_hi   = {1'b0, {(SB-1){1'b1}}};
  assign sat_lo   = {1'b1, {(SB-1){1'b0}}};
  assign in_stall = (state != S_IDLE);
  assign out_load = (state == S_OUT) && (!out_valid || !out_stall);

  assign mag32    = 32'(mag);
  assign mag_gt   = mag32 > env;
  assign env_diff = mag_gt ? (mag32 - env) : (env - mag32);
  assign env_next = mag_gt ? (mag32 - prod[47:16]) : (mag32 + prod[47:16]);

  assign amt      = 5'(5'd16 >> nstep);
  assign top_zero = (nrm >> (6'd32 - 6'(amt))) == 32'd0;
  assign nrm_next = top_zero ? (nrm << amt) : nrm;
  assign sq       = prod[62:30];

  assign top_l = 21'((SB - 1) << 16);
  assign log_l = {p, res};
  assign q     = (log_l > top_l) ? 21'd0 : (top_l - log_l);

  assign thr_abs   = threshold_db[10] ? 11'(-threshold_db) : 11'(threshold_db);
  assign mk_abs    = makeup_db[8] ? 9'(-makeup_db) : 9'(makeup_db);
  assign scaled_db = prod[34:18];
  assign mk_t      = makeup_db[8] ? -17'(signed'(scaled_db)) : 17'(signed'(scaled_db));
  assign gr_raw    = prod[35:16];

  assign fidx = 4'd9 - cnt;
  assign ip   = e[15:10];
  assign sh   = 6'(7'sd30 - 7'(ip));

  always_comb begin
    amag = amag_p >> sh;
    if (amag > (64'd1 << SB)) begin
      amag = 64'd1 << SB;
    end
    wet_full = x[SB-1] ? -(SB+2)'(amag) : (SB+2)'(amag);
  end

  assign y_full = (SB+2)'(acc >>> 16);
  assign w      = (wet_level > UNITY_Q16) ? UNITY_Q16 : wet_level;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_ENV: begin
        mul_a = MW'(env_diff);
        mul_b = MW'(mag_gt ? attack_coeff : release_coeff);
      end
      S_SQR: begin
        mul_a = MW'(m);
        mul_b = MW'(m);
      end
      S_THR: begin
        mul_a = MW'({thr_abs, 7'd0});
        mul_b = MW'(RECIP5);
      end
      S_LVL: begin
        mul_a = MW'(q);
        mul_b = MW'(DB_PER_LOG2);
      end
      S_RED: begin
        mul_a = MW'(over);
        mul_b = MW'(compress_slope);
      end
      S_MKP: begin
        mul_a = MW'({mk_abs, 7'd0});
        mul_b = MW'(RECIP5);
      end
      S_GAIN: begin
        mul_a = MW'(g);
        mul_b = MW'(LOG2_PER_DB);
      end
      S_EXPO: begin
        mul_a = MW'(m);
        mul_b = MW'(exp_k(cnt));
      end
      S_SCALE: begin
        mul_a = MW'(mag32);
        mul_b = MW'(m);
      end
      S_BLW: begin
        mul_a = MW'(wet);
        mul_b = MW'(w);
      end
      S_BLD: begin
        mul_a = MW'(x);
        mul_b = MW'(UNITY_Q16 - w);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold_db   <= THRESHOLD_RST;
      compress_slope <= SLOPE_RST;
      attack_coeff   <= ATTACK_RST;
      release_coeff  <= RELEASE_RST;
      makeup_db      <= MAKEUP_RST;
      wet_level      <= WET_RST;
      bypass_on      <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_THRESHOLD: threshold_db   <= cfg_data[10:0];
        REG_SLOPE:     compress_slope <= cfg_data[15:0];
        REG_ATTACK:    attack_coeff   <= cfg_data[15:0];
        REG_RELEASE:   release_coeff  <= cfg_data[15:0];
        REG_MAKEUP:    makeup_db      <= cfg_data[8:0];
        REG_WET:       wet_level      <= cfg_data;
        REG_BYPASS:    bypass_on      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      env       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            x     <= sample_in;
            mag   <= sample_in[SB-1] ? SB'(-sample_in) : SB'(sample_in);
            byp   <= bypass_on;
            state <= bypass_on ? S_OUT : S_ENV;
          end
        end
        S_ENV: begin
          env   <= env_next;
          nrm   <= env_next;
          p     <= 5'd31;
          nstep <= '0;
          if (env_next == 32'd0) begin
            gr    <= '0;
            state <= S_MKP;
          end else begin
            state <= S_NORM;
          end
        end
        S_NORM: begin
          nrm   <= nrm_next;
          nstep <= nstep + 3'd1;
          if (top_zero) begin
            p <= p - amt;
          end
          if (nstep == 3'd4) begin
            m     <= nrm_next >> 1;
            res   <= '0;
            cnt   <= '0;
            state <= S_SQR;
          end
        end
        S_SQR: begin
          res <= {res[14:0], sq[31]};
          m   <= sq[31] ? sq[32:1] : sq[31:0];
          cnt <= cnt + 4'd1;
          if (cnt == 4'd15) begin
            state <= S_THR;
          end
        end
        S_THR: begin
          t     <= threshold_db[10] ? -16'(scaled_db) : 16'(scaled_db);
          state <= S_LVL;
        end
        S_LVL: begin
          over  <= -20'(prod[32:16]) - 20'(t);
          state <= S_RED;
        end
        S_RED: begin
          if (over > 20'sd0) begin
            gr <= (gr_raw > 20'(GR_MAX)) ? GR_MAX : gr_raw[13:0];
          end else begin
            gr <= '0;
          end
          state <= S_MKP;
        end
        S_MKP: begin
          g     <= mk_t - 17'(signed'({1'b0, gr}));
          state <= S_GAIN;
        end
        S_GAIN: begin
          e     <= prod[31:16];
          m     <= 32'd1 << 30;
          cnt   <= '0;
          state <= S_EXPO;
        end
        S_EXPO: begin
          if (e[fidx]) begin
            m <= prod[61:30];
          end
          cnt <= cnt + 4'd1;
          if (cnt == 4'd9) begin
            state <= S_SCALE;
          end
        end
        S_SCALE: begin
          amag_p <= prod[63:0];
          state  <= S_SHIFT;
        end
        S_SHIFT: begin
          if (wet_full > (SB+2)'(sat_hi)) begin
            wet <= sat_hi;
          end else if (wet_full < (SB+2)'(sat_lo)) begin
            wet <= sat_lo;
          end else begin
            wet <= SB'(wet_full);
          end
          state <= S_BLW;
        end
        S_BLW: begin
          acc   <= prod[ACCW-1:0];
          state <= S_BLD;
        end
        S_BLD: begin
          acc   <= acc + prod[ACCW-1:0];
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (byp) begin
        sample_out     <= x;
        gain_reduction <= '0;
      end else begin
        gain_reduction <= gr;
        if (y_full > (SB+2)'(sat_hi)) begin
          sample_out <= sat_hi;
        end else if (y_full < (SB+2)'(sat_lo)) begin
          sample_out <= sat_lo;
        end else begin
          sample_out <= SB'(y_full);
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ sim/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import apc_pkg::*;

  localparam int SB = 24;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [SB-1:0] sample_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [SB-1:0] sample_out;
  logic [13:0] gain_reduction;

  audio_peak_compressor_core #(.SAMPLE_BITS(SB)) uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .sample_in(sample_in),
    .out_valid(out_valid), .out_stall(out_stall), .sample_out(sample_out),
    .gain_reduction(gain_reduction)
  );

  always #4 clk = ~clk;

  typedef struct packed {
    logic [SB-1:0] samp;
    logic [13:0]   gr;
  } comp_out_t;

  comp_out_t expected_q[$];
  int errors = 0;
  int results_seen = 0;
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int idle_cycles = 0;

  logic signed [10:0] m_thresh;
  logic [15:0] m_slope, m_attack, m_release;
  logic signed [8:0] m_makeup;
  logic [16:0] m_wet;
  logic m_bypass;
  logic [31:0] m_env;

  function automatic longint floor_div2(longint v, int sh);
    longint d;
    d = longint'(1) << sh;
    if (v >= 0) return v / d;
    return -((-v + d - 1) / d);
  endfunction

  function automatic longint clip_sample(longint v);
    longint hi;
    hi = (longint'(1) << (SB - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  function automatic logic [63:0] log2_fixed(logic [63:0] v);
    int p;
    logic [63:0] m, r;
    p = 0;
    while (p < 63 && (v >> (p + 1)) != 0) p++;
    m = (v << 30) >> p;
    r = 0;
    for (int k = 0; k < 16; k++) begin
      m = (m * m) >> 30;
      r = r << 1;
      if (m >= (64'd1 << 31)) begin
        r = r | 1;
        m = m >> 1;
      end
    end
    return (64'(p) << 16) | r;
  endfunction

  function automatic logic [63:0] pow_frac(int k);
    case (k)
      0: return 64'd1518500250;
      1: return 64'd1276901417;
      2: return 64'd1170923762;
      3: return 64'd1121280436;
      4: return 64'd1097253708;
      5: return 64'd1085434106;
      6: return 64'd1079572136;
      7: return 64'd1076653033;
      8: return 64'd1075196444;
      default: return 64'd1074468889;
    endcase
  endfunction

  function automatic comp_out_t compress_sample(logic signed [SB-1:0] s);
    comp_out_t r;
    longint x, g, e, ip, frac, wet, y, lvl, t, over;
    logic [63:0] mag, env, gr, mant, amag, w, top, l, q;
    int sh;
    x = longint'(s);
    mag = (x < 0) ? 64'(-x) : 64'(x);
    if (m_bypass) begin
      r.samp = s;
      r.gr = '0;
      return r;
    end
    env = 64'(m_env);
    if (mag > env) env = mag - (((mag - env) * m_attack) >> 16);
    else env = mag + (((env - mag) * m_release) >> 16);
    m_env = env[31:0];
    gr = 0;
    if (env != 0) begin
      top = 64'(SB - 1) << 16;
      l = log2_fixed(env);
      q = (l > top) ? 0 : top - l;
      lvl = -longint'((q * 1541) >> 16);
      t = longint'(m_thresh) * 256 / 10;
      over = lvl - t;
      if (over > 0) begin
        gr = (64'(over) * m_slope) >> 16;
        if (gr > 16383) gr = 16383;
      end
    end
    g = longint'(m_makeup) * 256 / 10 - longint'(gr);
    e = floor_div2(g * 43541, 16);
    ip = floor_div2(e, 10);
    frac = e - ip * 1024;
    mant = 64'd1 << 30;
    for (int k = 0; k < 10; k++)
      if ((frac >> (9 - k)) & 1) mant = (mant * pow_frac(k)) >> 30;
    sh = int'(30 - ip);
    if (sh > 63) sh = 63;
    amag = (mag * mant) >> sh;
    if (amag > (64'd1 << SB)) amag = 64'd1 << SB;
    wet = (x < 0) ? -longint'(amag) : longint'(amag);
    wet = clip_sample(wet);
    w = (m_wet > 17'd65536) ? 64'd65536 : 64'(m_wet);
    y = floor_div2(wet * longint'(w) + x * longint'(65536 - w), 16);
    y = clip_sample(y);
    r.samp = y[SB-1:0];
    r.gr = gr[13:0];
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      out_stall <= ($urandom_range(99) < receiver_stall_pct);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: FAIL");
        $finish;
      end
      if (out_valid && !out_stall) begin
        results_seen <= results_seen + 1;
        if (expected_q.size() == 0) begin
          $error("result with nothing expected: sample_out %0d gain_reduction %0d",
                 sample_out, gain_reduction);
          errors++;
        end else begin
          comp_out_t ex;
          ex = expected_q.pop_front();
          if (sample_out !== ex.samp) begin
            $error("sample_out expected %0d actual %0d", $signed(ex.samp), sample_out);
            errors++;
          end
          if (gain_reduction !== ex.gr) begin
            $error("gain_reduction expected %0d actual %0d", ex.gr, gain_reduction);
            errors++;
          end
        end
      end
    end
  end

  task automatic send_sample(logic signed [SB-1:0] s);
    cfg_we <= 1'b0;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    sample_in <= s;
    expected_q.insert(expected_q.size(), compress_sample(s));
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_THRESHOLD: m_thresh = val[10:0];
      REG_SLOPE: m_slope = val[15:0];
      REG_ATTACK: m_attack = val[15:0];
      REG_RELEASE: m_release = val[15:0];
      REG_MAKEUP: m_makeup = val[8:0];
      REG_WET: m_wet = val[16:0];
      REG_BYPASS: m_bypass = val[0];
      default: ;
    endcase
  endtask

  function automatic logic signed [SB-1:0] rand_sample();
    case ($urandom_range(5))
      0: return SB'($urandom);
      1: return SB'($signed($urandom_range(2000)) - 1000);
      2: return $urandom_range(1) ? 24'sh7FFFFF : 24'sh800000;
      default: return SB'($signed($urandom) >>> $urandom_range(20));
    endcase
  endfunction

  task automatic test_directed;
    send_sample(24'sd0);
    send_sample(24'sh7FFFFF);
    send_sample(24'sh800000);
    send_sample(24'sd1);
    send_sample(-24'sd1);
    send_sample(24'sh555555);
    send_sample(24'shAAAAAA);
    send_sample(24'sd0);
    drain();
    write_reg(REG_THRESHOLD, 17'(-11'sd600));
    write_reg(REG_SLOPE, 17'd62259);
    write_reg(REG_ATTACK, 17'd0);
    write_reg(REG_MAKEUP, 17'(9'sd240));
    write_reg(REG_WET, 17'h1FFFF);
    send_sample(24'sh7FFFFF);
    send_sample(24'sh800000);
    send_sample(24'sd12345);
    drain();
    write_reg(REG_BYPASS, 17'd1);
    send_sample(24'sh7FFFFF);
    send_sample(24'sh800000);
    send_sample(24'sd77);
    drain();
    write_reg(REG_BYPASS, 17'd0);
    write_reg(REG_THRESHOLD, 17'h3FF);
    write_reg(REG_MAKEUP, 17'(-9'sd120));
    write_reg(REG_WET, 17'd0);
    write_reg(REG_RELEASE, 17'hFFFF);
    send_sample(24'sh7FFFFF);
    send_sample(-24'sd5000);
    drain();
  endtask

  task automatic test_random_phase(int n, int idle, int stall);
    sender_idle_pct = idle;
    receiver_stall_pct = stall;
    write_reg(REG_THRESHOLD, 17'($signed($urandom_range(600)) - 600));
    write_reg(REG_SLOPE, 17'($urandom_range(62259)));
    write_reg(REG_ATTACK, $urandom_range(1) ? 17'($urandom_range(65535)) : 17'd65399);
    write_reg(REG_RELEASE, $urandom_range(1) ? 17'($urandom_range(65535)) : 17'd65522);
    write_reg(REG_MAKEUP, 17'($signed($urandom_range(360)) - 120));
    write_reg(REG_WET, $urandom_range(1) ? 17'd65536 : 17'($urandom_range(65536)));
    write_reg(REG_BYPASS, 17'($urandom_range(9) == 0));
    for (int i = 0; i < n; i++) send_sample(rand_sample());
    drain();
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
  endtask

  initial begin
    m_thresh = THRESHOLD_RST;
    m_slope = SLOPE_RST;
    m_attack = ATTACK_RST;
    m_release = RELEASE_RST;
    m_makeup = MAKEUP_RST;
    m_wet = WET_RST;
    m_bypass = 1'b0;
    m_env = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: test_random_phase(100, 0, 0);
        1: test_random_phase(100, 71, 0);
        2: test_random_phase(100, 0, 71);
        default: test_random_phase(100, 24, 24);
      endcase
    end
    $display("Covered register extremes, bypass, and random samples under sender gaps and");
    $display("receiver stalls; %0d results checked.", results_seen);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
